// ----- rtl/sweep_and_prune_pairs_assert.svh -----
// Assertion macros for the sweep-and-prune block.
`ifndef SWEEP_AND_PRUNE_PAIRS_ASSERT_SVH
`define SWEEP_AND_PRUNE_PAIRS_ASSERT_SVH
`ifndef SYNTHESIS
`define SPP_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("spp assertion failed");
`define SPP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spp assertion failed");
`else
`define SPP_ASSERT_NEVER(lbl, expr)
`define SPP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ----- rtl/spp_pkg.sv -----
package spp_pkg;

	localparam int unsigned ID_W        = 16;
	localparam int unsigned COORD_W     = 32;
	localparam int unsigned MAX_ENTRIES = 8;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] max_x;
	} pay_t;

	typedef struct packed {
		logic v;
		pay_t p;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic shift;
	} cmd_t;

endpackage

// ----- rtl/spp_cell.sv -----
module spp_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  spp_pkg::cmd_t   cmd,
	input  spp_pkg::entry_t new_e,
	input  spp_pkg::entry_t prev_main,
	input  logic            prev_gt,
	input  spp_pkg::entry_t next_main,
	input  spp_pkg::entry_t next_scan,
	output spp_pkg::entry_t main_e,
	output spp_pkg::entry_t scan_e,
	output logic            gt
);
	import spp_pkg::*;

	logic main_v_q;
	logic scan_v_q;
	pay_t main_p_q;
	pay_t scan_p_q;
	logic take_new;

	assign gt       = main_v_q && ($signed(main_p_q.min_x) > $signed(new_e.p.min_x));
	// new entry lands at the first cell holding a larger key, or the first free one
	assign take_new = !prev_gt && (gt || (!main_v_q && prev_main.v));
	assign main_e   = '{v: main_v_q, p: main_p_q};
	assign scan_e   = '{v: scan_v_q, p: scan_p_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			scan_v_q <= 1'b0;
		end else if (cmd.pop) begin
			main_v_q <= next_main.v;
			scan_v_q <= next_main.v;
		end else if (cmd.shift) begin
			scan_v_q <= next_scan.v;
		end else if (cmd.ins) begin
			if (prev_gt) begin
				main_v_q <= prev_main.v;
			end else if (take_new) begin
				main_v_q <= new_e.v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			main_p_q <= next_main.p;
			scan_p_q <= next_main.p;
		end else if (cmd.shift) begin
			scan_p_q <= next_scan.p;
		end else if (cmd.ins) begin
			if (prev_gt) begin
				main_p_q <= prev_main.p;
			end else if (take_new) begin
				main_p_q <= new_e.p;
			end
		end
	end

endmodule

// ----- rtl/sweep_and_prune_pairs.sv -----
// One-dimensional sweep-and-prune broad phase. Entries (id, min x, max x) are taken one
// per cycle while the block is idle and drop into a chain of cells kept sorted by min x,
// equal keys in arrival order; entries beyond MAX_ENTRIES are dropped and flagged in
// every result of that set. The entry flagged tlast starts the sweep, during which no
// input is taken: each held entry is popped off the chain head, and each overlap pair
// is found as the scan copy of the chain shifts past it, until a compare that finds no
// overlap stops that scan. Pairs come out in sorted order at up to one per cycle;
// a set without pairs yields one marker result. The output is registered and the sweep
// stalls only when a result waits unaccepted.
`include "sweep_and_prune_pairs_assert.svh"
module sweep_and_prune_pairs #(
	parameter int unsigned MAX_ENTRIES = spp_pkg::MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // entity_id[15:0], min_x[47:16], max_x[79:48]
	input  logic        s_tlast,  // last_entry
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // first_id[15:0], second_id[31:16]
	output logic [1:0]  m_tuser,  // no_pairs[0], dropped[1]
	output logic        m_tlast   // last_result
);
	import spp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_POP  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t                       st_q;
	entry_t                    new_e;
	entry_t                    main_e [MAX_ENTRIES];
	entry_t                    scan_e [MAX_ENTRIES];
	logic   [MAX_ENTRIES-1:0]  gt;
	logic   [MAX_ENTRIES-1:0]  main_valid;
	cmd_t                      cmd;
	logic                      s_acc;
	logic                      full;
	logic                      pair_hit;
	logic                      out_free;
	logic                      out_load;

	logic                      ovf_q;
	logic [ID_W-1:0]           a_id_q;
	logic signed [COORD_W-1:0] a_max_q;
	logic                      pend_v_q;
	logic [ID_W-1:0]           pend_first_q;
	logic [ID_W-1:0]           pend_second_q;
	logic                      out_v_q;
	logic [ID_W-1:0]           out_first_q;
	logic [ID_W-1:0]           out_second_q;
	logic                      out_none_q;
	logic                      out_drop_q;
	logic                      out_last_q;

	assign new_e.v       = 1'b1;
	assign new_e.p.id    = s_tdata[15:0];
	assign new_e.p.min_x = s_tdata[47:16];
	assign new_e.p.max_x = s_tdata[79:48];

	assign s_tready = (st_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign full     = main_e[MAX_ENTRIES-1].v;
	assign pair_hit = scan_e[0].v && ($signed(scan_e[0].p.min_x) <= a_max_q);
	assign out_free = !out_v_q || m_tready;
	assign out_load = (cmd.shift && pend_v_q) || ((st_q == ST_DONE) && out_free);

	assign cmd.ins   = s_acc && !full;
	assign cmd.pop   = (st_q == ST_POP) && main_e[0].v;
	assign cmd.shift = (st_q == ST_SCAN) && pair_hit && (!pend_v_q || out_free);

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		entry_t prev_m;
		entry_t next_m;
		entry_t next_s;
		logic   prev_g;

		if (k == 0) begin : g_head
			assign prev_m = '{v: 1'b1, p: '0};
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_m = main_e[k-1];
			assign prev_g = gt[k-1];
		end
		if (k == MAX_ENTRIES - 1) begin : g_tail
			assign next_m = '0;
			assign next_s = '0;
		end else begin : g_inner
			assign next_m = main_e[k+1];
			assign next_s = scan_e[k+1];
		end

		spp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_e     (new_e),
			.prev_main (prev_m),
			.prev_gt   (prev_g),
			.next_main (next_m),
			.next_scan (next_s),
			.main_e    (main_e[k]),
			.scan_e    (scan_e[k]),
			.gt        (gt[k])
		);

		assign main_valid[k] = main_e[k].v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ovf_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= out_load || (out_v_q && !m_tready);
			case (st_q)
				ST_IDLE: begin
					if (s_acc && full) begin
						ovf_q <= 1'b1;
					end
					if (s_acc && s_tlast) begin
						st_q <= ST_POP;
					end
				end
				ST_POP: begin
					st_q <= main_e[0].v ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					if (!pair_hit) begin
						st_q <= ST_POP;
					end else if (cmd.shift) begin
						pend_v_q <= 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						ovf_q    <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			a_id_q  <= main_e[0].p.id;
			a_max_q <= main_e[0].p.max_x;
		end
		if (cmd.shift) begin
			pend_first_q  <= a_id_q;
			pend_second_q <= scan_e[0].p.id;
			if (pend_v_q) begin
				out_first_q  <= pend_first_q;
				out_second_q <= pend_second_q;
				out_none_q   <= 1'b0;
				out_drop_q   <= ovf_q;
				out_last_q   <= 1'b0;
			end
		end
		if ((st_q == ST_DONE) && out_free) begin
			out_first_q  <= pend_v_q ? pend_first_q : '0;
			out_second_q <= pend_v_q ? pend_second_q : '0;
			out_none_q   <= !pend_v_q;
			out_drop_q   <= ovf_q;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_second_q, out_first_q};
	assign m_tuser  = {out_drop_q, out_none_q};
	assign m_tlast  = out_last_q;

	// held entries always form an unbroken run from the chain head
	`SPP_ASSERT_NEVER(a_chain_contig, (main_valid & (main_valid + 1'b1)) != '0)
	`SPP_ASSERT_NEVER(a_pend_idle, pend_v_q && (st_q == ST_IDLE))
	`SPP_ASSERT_IMPL(a_marker_ids, out_v_q && out_none_q, (out_first_q == '0) && out_last_q)

	for (genvar k = 0; k < MAX_ENTRIES - 1; k++) begin : g_order_chk
		`SPP_ASSERT_IMPL(a_sorted, main_e[k+1].v, main_e[k].p.min_x <= main_e[k+1].p.min_x)
	end

endmodule

// ----- dv/sweep_and_prune_pairs_tb.sv -----
`timescale 1ns / 100ps

module sweep_and_prune_pairs_tb;

	localparam int CAP      = spp_pkg::MAX_ENTRIES;
	localparam int WDOG_MAX = 2000;

	typedef struct {
		logic [15:0] id;
		logic [31:0] lo;
		logic [31:0] hi;
		bit          last;
		bit          hold;  // wait for all pairs of earlier sets first
	} collider_t;

	typedef struct packed {
		logic [15:0] first_id;
		logic [15:0] second_id;
		logic        no_pairs;
		logic        dropped;
		logic        last_result;
	} pair_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	collider_t       pending[$];
	collider_t       cur;
	pair_t           pairs_due[$];
	spp_pkg::pay_t   held[CAP];
	int              held_n;
	bit              spilled;
	int              err_count;
	int              idle_cycles;
	bit              in_acc;
	bit              out_acc;
	int              s_gap;
	int              m_wait;
	bit              s_burst;
	bit              m_burst;

	sweep_and_prune_pairs u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	// stable sorted insert; sweep on the last entry of a set
	task automatic take_entry(input logic [15:0] id, input logic [31:0] lo,
			input logic [31:0] hi, input logic last);
		int    pos;
		int    found;
		pair_t r;
		if (held_n >= CAP) begin
			spilled = 1'b1;
		end else begin
			pos = held_n;
			while (pos > 0 && $signed(held[pos-1].min_x) > $signed(lo)) begin
				held[pos] = held[pos-1];
				pos--;
			end
			held[pos].id    = id;
			held[pos].min_x = lo;
			held[pos].max_x = hi;
			held_n++;
		end
		if (last) begin
			found = 0;
			for (int i = 0; i < held_n; i++) begin
				for (int j = i + 1; j < held_n; j++) begin
					if ($signed(held[j].min_x) > $signed(held[i].max_x))
						break;
					r.first_id    = held[i].id;
					r.second_id   = held[j].id;
					r.no_pairs    = 1'b0;
					r.dropped     = spilled;
					r.last_result = 1'b0;
					pairs_due = {pairs_due, r};
					found++;
				end
			end
			if (found == 0) begin
				r.first_id    = '0;
				r.second_id   = '0;
				r.no_pairs    = 1'b1;
				r.dropped     = spilled;
				r.last_result = 1'b1;
				pairs_due = {pairs_due, r};
			end else begin
				pairs_due[pairs_due.size()-1].last_result = 1'b1;
			end
			held_n  = 0;
			spilled = 1'b0;
		end
	endtask

	task automatic check_pair();
		pair_t got;
		pair_t want;
		got = {m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1], m_tlast};
		if (pairs_due.size() == 0) begin
			note_mismatch($sformatf("result with none due: ids %h/%h none %b drop %b last %b",
				got.first_id, got.second_id, got.no_pairs, got.dropped, got.last_result));
		end else begin
			want = pairs_due.pop_front();
			if (got.first_id != want.first_id || got.second_id != want.second_id ||
					got.no_pairs != want.no_pairs || got.dropped != want.dropped ||
					got.last_result != want.last_result)
				note_mismatch($sformatf(
					"exp ids %h/%h none %b drop %b last %b, got ids %h/%h none %b drop %b last %b",
					want.first_id, want.second_id, want.no_pairs, want.dropped,
					want.last_result, got.first_id, got.second_id, got.no_pairs,
					got.dropped, got.last_result));
		end
	endtask

	task automatic add_item(input logic [15:0] id, input logic [31:0] lo,
			input logic [31:0] hi, input bit last, input bit hold);
		collider_t c;
		c.id   = id;
		c.lo   = lo;
		c.hi   = hi;
		c.last = last;
		c.hold = hold;
		pending = {pending, c};
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_acc) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() != 0 &&
						!(pending[0].hold && pairs_due.size() != 0)) begin
					cur = pending.pop_front();
					s_tdata  <= {cur.hi, cur.lo, cur.id};
					s_tlast  <= cur.last;
					s_tvalid <= 1'b1;
					if ($urandom_range(0, 23) == 0)
						s_burst = !s_burst;
					s_gap = s_burst ? 0 : $urandom_range(0, 7);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_acc) begin
				if ($urandom_range(0, 23) == 0)
					m_burst = !m_burst;
				m_wait = m_burst ? 0 : $urandom_range(0, 7);
			end
			if (m_wait > 0) begin
				m_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		in_acc  <= s_tvalid && s_tready;
		out_acc <= m_tvalid && m_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				take_entry(s_tdata[15:0], s_tdata[47:16], s_tdata[79:48], s_tlast);
			if (m_tvalid && m_tready)
				check_pair();
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else if (pending.size() != 0 || s_tvalid || pairs_due.size() != 0)
				idle_cycles++;
			if (idle_cycles >= WDOG_MAX) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int          n;
		int          sz;
		bit          wide;
		bit          hold;
		logic [31:0] lo;
		logic [31:0] hi;

		// lone entry spanning the whole axis
		add_item(16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
		// extremes, no overlap
		add_item(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);
		add_item(16'h0001, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
		// equal keys keep arrival order
		add_item(16'd10, 32'd5, 32'd5, 1'b0, 1'b1);
		add_item(16'd11, 32'd5, 32'd5, 1'b0, 1'b0);
		add_item(16'd12, 32'd5, 32'd5, 1'b1, 1'b0);
		// inverted boxes
		add_item(16'd20, 32'd100, -32'sd100, 1'b0, 1'b1);
		add_item(16'd21, 32'd50, 32'd200, 1'b0, 1'b0);
		add_item(16'd22, -32'sd300, -32'sd400, 1'b1, 1'b0);
		// ten overlapping entries: two dropped, the last one carries the flag
		for (int k = 0; k < 10; k++)
			add_item(16'(16'h5A00 + k), 32'd1000 - k, 32'd5000, k == 9, k == 0);

		n = pending.size();
		while (n < 400) begin
			sz   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
			wide = ($urandom_range(0, 5) == 0);
			hold = ($urandom_range(0, 9) == 0);
			for (int k = 0; k < sz; k++) begin
				if (wide) begin
					lo = $urandom;
					hi = $urandom;
				end else begin
					lo = 10 * $urandom_range(0, 20) - 100;
					hi = lo + $urandom_range(0, 80) - 10;
				end
				add_item(16'($urandom), lo, hi, k == sz - 1, hold && k == 0);
			end
			n += sz;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pairs_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/spp_pkg.sv
rtl/spp_cell.sv
rtl/sweep_and_prune_pairs.sv
dv/sweep_and_prune_pairs_tb.sv
